// ----- hw/rtl/stup_pkg.sv -----
// ----------------------------------------------------------------------------
// stup_pkg
// Shared types, character codes and digit decoding for the string to
// unsigned parser.
// ----------------------------------------------------------------------------
package stup_pkg;

	typedef enum logic [2:0] {
		PH_SPACE  = 3'd0,
		PH_FIRST  = 3'd1,
		PH_ZERO   = 3'd2,
		PH_DIGITS = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	typedef struct packed {
		logic [63:0] value;
		logic [15:0] offset;
	} result_t;

	typedef struct packed {
		logic       ok;
		logic [4:0] val;
	} digit_t;

	localparam logic [7:0] ChNul   = 8'h00;
	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChLf    = 8'h0A;
	localparam logic [7:0] ChVt    = 8'h0B;
	localparam logic [7:0] ChFf    = 8'h0C;
	localparam logic [7:0] ChCr    = 8'h0D;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChPlus  = 8'h2B;
	localparam logic [7:0] ChMinus = 8'h2D;
	localparam logic [7:0] Ch0     = 8'h30;
	localparam logic [7:0] Ch9     = 8'h39;
	localparam logic [7:0] ChUpA   = 8'h41;
	localparam logic [7:0] ChUpF   = 8'h46;
	localparam logic [7:0] ChUpX   = 8'h58;
	localparam logic [7:0] ChLoA   = 8'h61;
	localparam logic [7:0] ChLoF   = 8'h66;
	localparam logic [7:0] ChLoX   = 8'h78;

	localparam logic [4:0] BaseAuto = 5'd0;
	localparam logic [4:0] BaseOct  = 5'd8;
	localparam logic [4:0] BaseDec  = 5'd10;
	localparam logic [4:0] BaseHex  = 5'd16;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChCr) ||
			(c == ChFf) || (c == ChVt);
	endfunction

	function automatic digit_t digit_of(input logic [7:0] c, input logic [4:0] base);
		digit_t d;
		d.ok  = 1'b0;
		d.val = '0;
		if (base <= BaseDec) begin
			if ((c >= Ch0) && ({1'b0, c} < ({1'b0, Ch0} + {4'b0, base}))) begin
				d.ok  = 1'b1;
				d.val = 5'(c - Ch0);
			end
		end else begin
			if ((c >= Ch0) && (c <= Ch9)) begin
				d.ok  = 1'b1;
				d.val = 5'(c - Ch0);
			end else if ((c >= ChLoA) && (c <= ChLoF)) begin
				d.ok  = 1'b1;
				d.val = 5'(c - ChLoA) + BaseDec;
			end else if ((c >= ChUpA) && (c <= ChUpF)) begin
				d.ok  = 1'b1;
				d.val = 5'(c - ChUpA) + BaseDec;
			end
			if (d.val >= base) begin
				d.ok = 1'b0;
			end
		end
		return d;
	endfunction

endpackage

// ----- hw/rtl/stup_parser.sv -----
// ----------------------------------------------------------------------------
// stup_parser
// Parse state and the per-character step: white space, sign, base prefix
// and digit accumulation, with the result formed at the terminator.
// ----------------------------------------------------------------------------
module stup_parser #(
	parameter int MAX_LENGTH = 65535
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  logic [7:0]           char_in,
	input  logic [4:0]           number_base,
	output stup_pkg::result_t    result
);

	localparam logic [15:0] MaxPos = 16'(MAX_LENGTH);

	stup_pkg::phase_t phase_q, phase_n;
	logic [4:0]       base_q, base_n;
	logic             neg_q, neg_n;
	logic [63:0]      acc_q, acc_n;
	logic [15:0]      pos_q, pos_n;
	logic [15:0]      stop_q, stop_n;
	logic [15:0]      pos_inc;
	logic             taken;
	stup_pkg::digit_t dig;

	assign pos_inc = (pos_q >= MaxPos) ? MaxPos : pos_q + 16'd1;

	always_comb begin
		phase_n = phase_q;
		base_n  = base_q;
		neg_n   = neg_q;
		acc_n   = acc_q;
		taken   = 1'b0;
		dig     = '0;
		if (phase_n == stup_pkg::PH_SPACE) begin
			if (stup_pkg::is_blank(char_in)) begin
				taken = 1'b1;
			end else if ((char_in == stup_pkg::ChPlus) || (char_in == stup_pkg::ChMinus)) begin
				neg_n   = (char_in == stup_pkg::ChMinus);
				phase_n = stup_pkg::PH_FIRST;
				taken   = 1'b1;
			end else begin
				phase_n = stup_pkg::PH_FIRST;
			end
		end
		if (!taken && (phase_n == stup_pkg::PH_FIRST)) begin
			if (((number_base == stup_pkg::BaseAuto) || (number_base == stup_pkg::BaseHex)) &&
				(char_in == stup_pkg::Ch0)) begin
				base_n  = (number_base == stup_pkg::BaseAuto) ? stup_pkg::BaseOct
					: stup_pkg::BaseHex;
				acc_n   = '0;
				phase_n = stup_pkg::PH_ZERO;
				taken   = 1'b1;
			end else begin
				base_n  = (number_base == stup_pkg::BaseAuto) ? stup_pkg::BaseDec : number_base;
				phase_n = stup_pkg::PH_DIGITS;
			end
		end
		if (!taken && (phase_n == stup_pkg::PH_ZERO)) begin
			if ((char_in == stup_pkg::ChLoX) || (char_in == stup_pkg::ChUpX)) begin
				base_n = stup_pkg::BaseHex;
				taken  = 1'b1;
			end
			phase_n = stup_pkg::PH_DIGITS;
		end
		if (!taken && (phase_n == stup_pkg::PH_DIGITS)) begin
			dig = stup_pkg::digit_of(char_in, base_n);
			if (dig.ok) begin
				acc_n = acc_q * 64'(base_n) + 64'(dig.val);
				taken = 1'b1;
			end else begin
				phase_n = stup_pkg::PH_DONE;
			end
		end
	end

	always_comb begin
		pos_n  = pos_inc;
		stop_n = taken ? pos_inc : stop_q;
	end

	always_comb begin
		result.value  = neg_q ? (~acc_q + 64'd1) : acc_q;
		result.offset = stop_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= stup_pkg::PH_SPACE;
			base_q  <= '0;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			pos_q   <= '0;
			stop_q  <= '0;
		end else if (step_en) begin
			if (char_in == stup_pkg::ChNul) begin
				phase_q <= stup_pkg::PH_SPACE;
				base_q  <= '0;
				neg_q   <= 1'b0;
				acc_q   <= '0;
				pos_q   <= '0;
				stop_q  <= '0;
			end else begin
				phase_q <= phase_n;
				base_q  <= base_n;
				neg_q   <= neg_n;
				acc_q   <= acc_n;
				pos_q   <= pos_n;
				stop_q  <= stop_n;
			end
		end
	end

endmodule

// ----- hw/rtl/string_to_unsigned_parser_core.sv -----
// ----------------------------------------------------------------------------
// string_to_unsigned_parser_core
// Streaming string to unsigned integer parser in the style of strtoul.
// ----------------------------------------------------------------------------
// One string byte enters per transaction on the slave side, and a zero byte
// ends the string; that terminator, and only it, yields one transaction on the
// master side with the 64-bit value and the end offset. A new byte is taken in
// every cycle unless a held terminator stalls it: each byte is registered in the
// input register and folded into the parse state by a single multiply-add by
// the radix, and the result is registered at the output. Only a terminator that
// meets a still untaken result waits. The radix register is sampled at the
// first character after white space and sign.
module string_to_unsigned_parser_core #(
	parameter int MAX_LENGTH = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata    // [63:0] parsed_value, [79:64] end_offset
);

	logic [4:0]         base_q;
	logic               valid_s1;
	logic [7:0]         char_s1;
	logic               step_en;
	logic               out_free;
	logic               is_term;
	logic               out_valid_q;
	stup_pkg::result_t  out_q;
	stup_pkg::result_t  result;

	assign is_term       = (char_s1 == stup_pkg::ChNul);
	assign out_free      = !out_valid_q || m_axis_tready;
	assign step_en       = valid_s1 && (!is_term || out_free);
	assign s_axis_tready = !valid_s1 || step_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
		end
	end

	stup_parser #(
		.MAX_LENGTH(MAX_LENGTH)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (step_en),
		.char_in    (char_s1),
		.number_base(base_q),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en && is_term) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && is_term) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.offset, out_q.value};

endmodule

// ----- dv/tb_string_to_unsigned_parser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_string_to_unsigned_parser_core
// Self-checking bench for the streaming strtoul-style parser. Strings are fed
// one byte per transaction. A cycle-free model predicts each value and end
// offset. Directed strings cover radix detection, prefixes, signs, radix
// extremes, mid-string radix writes, trailing junk and long strings.
// Random strings follow under three sender/receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_string_to_unsigned_parser_core;

	localparam int MaxLength = 65535;

	typedef struct packed {
		logic [15:0] offset;
		logic [63:0] value;
	} parse_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [4:0]  cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] char_in
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;   // [63:0] parsed_value, [79:64] end_offset

	string_to_unsigned_parser_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	int src_idle_pct;
	int snk_idle_pct;
	int mismatch_count;
	int chars_sent;
	int strings_sent;
	int results_checked;
	int radix_writes;

	parse_result_t pending_parses[$];

	// Mirror of the parser.
	logic [4:0]        radix_setting;
	stup_pkg::phase_t  scan_phase;
	logic [4:0]        scan_radix;
	logic              scan_negative;
	logic [63:0]       scan_value;
	logic [15:0]       scan_pos;
	logic [15:0]       scan_stop;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			check_result(m_axis_tdata);
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_result(input logic [79:0] data);
		parse_result_t want;
		if (pending_parses.size() == 0) begin
			report_mismatch("result with none expected", data[63:0], 64'd0);
			return;
		end
		want = pending_parses.pop_front();
		results_checked++;
		if (data[63:0] !== want.value) begin
			report_mismatch("parsed_value", data[63:0], want.value);
		end
		if (data[79:64] !== want.offset) begin
			report_mismatch("end_offset", 64'(data[79:64]), 64'(want.offset));
		end
	endtask

	function automatic logic [15:0] next_pos(input logic [15:0] p);
		return (p >= 16'(MaxLength)) ? 16'(MaxLength) : p + 16'd1;
	endfunction

	function automatic int digit_value(input logic [7:0] c, input logic [4:0] radix);
		int v;
		if (c >= stup_pkg::Ch0 && c <= stup_pkg::Ch9) begin
			v = int'(c - stup_pkg::Ch0);
		end else if (c >= stup_pkg::ChLoA && c <= stup_pkg::ChLoF) begin
			v = int'(c - stup_pkg::ChLoA) + 10;
		end else if (c >= stup_pkg::ChUpA && c <= stup_pkg::ChUpF) begin
			v = int'(c - stup_pkg::ChUpA) + 10;
		end else begin
			return -1;
		end
		return (v < int'(radix)) ? v : -1;
	endfunction

	task automatic clear_scan();
		scan_phase    = stup_pkg::PH_SPACE;
		scan_radix    = '0;
		scan_negative = 1'b0;
		scan_value    = '0;
		scan_pos      = '0;
		scan_stop     = '0;
	endtask

	task automatic parse_char(input logic [7:0] c);
		logic          took;
		int            d;
		parse_result_t res;
		took = 1'b0;
		if (scan_phase == stup_pkg::PH_SPACE) begin
			if (c inside {stup_pkg::ChSpace, stup_pkg::ChTab, stup_pkg::ChLf,
					stup_pkg::ChCr, stup_pkg::ChFf, stup_pkg::ChVt}) begin
				took = 1'b1;
			end else begin
				if (c == stup_pkg::ChPlus || c == stup_pkg::ChMinus) begin
					scan_negative = (c == stup_pkg::ChMinus);
					took = 1'b1;
				end
				scan_phase = stup_pkg::PH_FIRST;
			end
		end
		if (!took && scan_phase == stup_pkg::PH_FIRST) begin
			if ((radix_setting == stup_pkg::BaseAuto || radix_setting == stup_pkg::BaseHex) &&
					c == stup_pkg::Ch0) begin
				scan_radix = (radix_setting == stup_pkg::BaseAuto) ? stup_pkg::BaseOct
					: stup_pkg::BaseHex;
				scan_value = '0;
				scan_phase = stup_pkg::PH_ZERO;
				took = 1'b1;
			end else begin
				scan_radix = (radix_setting == stup_pkg::BaseAuto) ? stup_pkg::BaseDec
					: radix_setting;
				scan_phase = stup_pkg::PH_DIGITS;
			end
		end
		if (!took && scan_phase == stup_pkg::PH_ZERO) begin
			if (c == stup_pkg::ChLoX || c == stup_pkg::ChUpX) begin
				scan_radix = stup_pkg::BaseHex;
				took = 1'b1;
			end
			scan_phase = stup_pkg::PH_DIGITS;
		end
		if (!took && scan_phase == stup_pkg::PH_DIGITS) begin
			d = digit_value(c, scan_radix);
			if (d >= 0) begin
				scan_value = scan_value * 64'(scan_radix) + 64'(d);
				took = 1'b1;
			end else begin
				scan_phase = stup_pkg::PH_DONE;
			end
		end
		if (took) begin
			scan_stop = next_pos(scan_pos);
		end
		scan_pos = next_pos(scan_pos);
		if (c == stup_pkg::ChNul) begin
			res.value  = scan_negative ? (~scan_value + 64'd1) : scan_value;
			res.offset = scan_stop;
			pending_parses.push_back(res);
			strings_sent++;
			clear_scan();
		end
	endtask

	task automatic send_char(input logic [7:0] c);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		do @(posedge clk); while (!s_axis_tready);
		chars_sent++;
		parse_char(c);
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i]);
		end
		send_char(stup_pkg::ChNul);
	endtask

	task automatic wait_for_results();
		int n;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		n = 0;
		while (pending_parses.size() != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (8) @(posedge clk);
		if (pending_parses.size() != 0) begin
			report_mismatch("results never arrived", 64'(pending_parses.size()), 64'd0);
			pending_parses.delete();
		end
	endtask

	task automatic write_radix(input logic [4:0] radix);
		wait_for_results();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= radix;
		@(posedge clk);
		radix_setting = radix;
		radix_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_idle(input int src_pct, input int snk_pct);
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
	endtask

	function automatic logic [7:0] blank_char();
		case ($urandom_range(0, 5))
			0: return stup_pkg::ChSpace;
			1: return stup_pkg::ChTab;
			2: return stup_pkg::ChLf;
			3: return stup_pkg::ChCr;
			4: return stup_pkg::ChFf;
			default: return stup_pkg::ChVt;
		endcase
	endfunction

	function automatic logic [7:0] digit_char(input int v);
		if (v < 10) begin
			return stup_pkg::Ch0 + 8'(v);
		end
		return ($urandom_range(0, 1) != 0) ? stup_pkg::ChLoA + 8'(v - 10)
			: stup_pkg::ChUpA + 8'(v - 10);
	endfunction

	function automatic logic [7:0] x_char();
		return ($urandom_range(0, 1) != 0) ? stup_pkg::ChLoX : stup_pkg::ChUpX;
	endfunction

	function automatic logic [4:0] random_radix();
		case ($urandom_range(0, 9))
			0, 1, 2: return stup_pkg::BaseAuto;
			3: return stup_pkg::BaseDec;
			4: return stup_pkg::BaseHex;
			5: return stup_pkg::BaseOct;
			6: return 5'd2;
			7: return 5'd1;
			default: return 5'($urandom_range(0, 31));
		endcase
	endfunction

	task automatic send_number(input logic [4:0] radix);
		int top;
		int kind;
		int n_digits;
		repeat ($urandom_range(0, 3)) send_char(blank_char());
		kind = $urandom_range(0, 2);
		if (kind == 1) begin
			send_char(stup_pkg::ChPlus);
		end else if (kind == 2) begin
			send_char(stup_pkg::ChMinus);
		end
		top = int'(radix);
		if (radix == stup_pkg::BaseAuto) begin
			kind = $urandom_range(0, 3);
			if (kind == 0) begin
				send_char(stup_pkg::Ch0);
				send_char(x_char());
				top = 16;
			end else if (kind == 1) begin
				send_char(stup_pkg::Ch0);
				top = 8;
			end else begin
				top = 10;
			end
		end else if (radix == stup_pkg::BaseHex && $urandom_range(0, 1) != 0) begin
			send_char(stup_pkg::Ch0);
			send_char(x_char());
		end
		if (top > 16) begin
			top = 16;
		end
		n_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 30) : $urandom_range(0, 12);
		repeat (n_digits) send_char(digit_char($urandom_range(0, top - 1)));
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(1, 255)));
		end
		send_char(stup_pkg::ChNul);
	endtask

	task automatic send_noise();
		case ($urandom_range(0, 2))
			0: send_char(stup_pkg::ChMinus);
			1: begin
				send_char(stup_pkg::Ch0);
				send_char(x_char());
			end
			default: ;
		endcase
		repeat ($urandom_range(0, 10)) send_char(8'($urandom_range(1, 255)));
		send_char(stup_pkg::ChNul);
	endtask

	task automatic test_auto_radix();
		write_radix(stup_pkg::BaseAuto);
		send_string("0x1F");
		send_string("0X7fFf");
		send_string("017");
		send_string("08");
		send_string("123");
		send_string("  -42");
		send_string("+0");
		send_string("0x");
		send_string("0xg");
		send_string("");
		send_string("-");
		send_string("+-5");
		send_string("18446744073709551615");
		send_string("18446744073709551616");
		send_string("-1");
		send_char(stup_pkg::ChTab);
		send_char(stup_pkg::ChLf);
		send_char(stup_pkg::ChVt);
		send_char(stup_pkg::ChFf);
		send_char(stup_pkg::ChCr);
		send_string(" 9");
	endtask

	task automatic test_fixed_radix();
		write_radix(5'd1);
		send_string("0001");
		write_radix(5'd2);
		send_string("1011");
		send_string("-12");
		write_radix(stup_pkg::BaseDec);
		send_string("0x10");
		write_radix(5'd11);
		send_string("aA");
		send_string("b");
		write_radix(stup_pkg::BaseHex);
		send_string("0xFFFFFFFFFFFFFFFF");
		send_string("-ff");
		send_string("0x");
		send_string("0g");
		write_radix(5'd31);
		send_string("fF9z");
		write_radix(stup_pkg::BaseOct);
		send_string("778");
	endtask

	task automatic test_mid_string_write();
		write_radix(stup_pkg::BaseDec);
		send_char(stup_pkg::ChSpace);
		send_char(stup_pkg::ChSpace);
		write_radix(stup_pkg::BaseHex);
		send_string("ff");
		send_char(stup_pkg::Ch0 + 8'd1);
		write_radix(stup_pkg::BaseOct);
		send_string("f");
		send_string("17");
	endtask

	task automatic test_trailing_chars();
		write_radix(stup_pkg::BaseDec);
		send_string("12abc");
		send_string("7 8 9");
		send_char(stup_pkg::Ch0 + 8'd5);
		send_char(8'h80);
		send_char(8'hFF);
		send_string("6");
	endtask

	task automatic test_long_strings();
		write_radix(stup_pkg::BaseDec);
		repeat (60) send_char(stup_pkg::Ch9);
		send_char(stup_pkg::ChNul);
		send_char(stup_pkg::ChSpace);
		send_char(stup_pkg::Ch0 + 8'd5);
		repeat (60) send_char(stup_pkg::ChLoX);
		send_char(stup_pkg::ChNul);
	endtask

	task automatic test_random_strings(input int n_chars);
		int stop_at;
		stop_at = chars_sent + n_chars;
		while (chars_sent < stop_at) begin
			if ($urandom_range(0, 11) == 0) begin
				write_radix(random_radix());
			end
			if ($urandom_range(0, 4) == 0) begin
				send_noise();
			end else begin
				send_number(radix_setting);
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		radix_setting = stup_pkg::BaseAuto;
		clear_scan();
		set_idle(0, 0);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_idle(6, 76);
		test_auto_radix();
		test_fixed_radix();
		test_mid_string_write();
		test_trailing_chars();
		test_random_strings(450);

		set_idle(76, 6);
		write_radix(stup_pkg::BaseAuto);
		test_random_strings(450);

		set_idle(0, 0);
		test_long_strings();
		test_random_strings(460);
		wait_for_results();

		$display("tb: %0d characters in %0d strings, %0d results checked",
			chars_sent, strings_sent, results_checked);
		$display("tb: %0d radix writes from 0 to 31, three stall mixes, long strings",
			radix_writes);
		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
